/* src/pds_pkg.sv */
// shared widths, codes and helpers for the differential steering pid core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int SUM_W       = 24;
  localparam int LIMIT_W     = 23;
  localparam int BASE_W      = 15;
  localparam int CFG_W       = 23;
  localparam int CFG_IDX_W   = 3;
  localparam int DERIV_W     = SAMPLE_W + 1;
  localparam int PROD_P_W    = GAIN_W + 1 + SAMPLE_W;
  localparam int PROD_I_W    = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W    = GAIN_W + 1 + DERIV_W;
  localparam int ACC_W       = PROD_I_W + 2;
  localparam int SHIFTED_W   = ACC_W - GAIN_FRAC;

  typedef enum logic [1:0] {
    MODE_RIGHT    = 2'd0,
    MODE_LEFT     = 2'd1,
    MODE_STRAIGHT = 2'd2,
    MODE_NO_WALL  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_SUM_LIMIT    = 3'd3,
    REG_CRUISE_SPEED = 3'd4
  } reg_idx_t;

  // error stage result handed to the multiply stage
  typedef struct packed {
    logic                       search;
    logic signed [SAMPLE_W-1:0] err;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DERIV_W-1:0]  deriv;
  } err_stage_t;

  // saturate a sum that grew by one bit back to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SAMPLE_W:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = {v[SAMPLE_W], {(SAMPLE_W-1){~v[SAMPLE_W]}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/pds_if.sv */
// valid/ready channel interfaces for steering commands and wheel results
// depends on pds_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pds_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic signed [pds_pkg::SAMPLE_W-1:0] deviation;

  modport source (output valid, output mode, output deviation, input ready);
  modport sink   (input valid, input mode, input deviation, output ready);
endinterface

interface pds_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pds_pkg::SAMPLE_W-1:0] left_speed;
  logic signed [pds_pkg::SAMPLE_W-1:0] right_speed;
  logic signed [pds_pkg::SAMPLE_W-1:0] drive_term;
  logic                                searching;

  modport source (output valid, output left_speed, output right_speed,
                  output drive_term, output searching, input ready);
  modport sink   (input valid, input left_speed, input right_speed,
                  input drive_term, input searching, output ready);
endinterface

`default_nettype wire

/* src/pds_error_stage.sv */
// error forming and clamped integral update for one command
// depends on pds_pkg
`timescale 1ns / 1ps
`default_nettype none

module pds_error_stage (
  input  wire logic [1:0]                          mode,
  input  wire logic signed [pds_pkg::SAMPLE_W-1:0] deviation,
  input  wire logic signed [pds_pkg::SUM_W-1:0]    error_sum,
  input  wire logic signed [pds_pkg::SAMPLE_W-1:0] last_error,
  input  wire logic [pds_pkg::LIMIT_W-1:0]         sum_limit,
  output pds_pkg::err_stage_t                      res
);

  localparam int SW = pds_pkg::SAMPLE_W;
  localparam int UW = pds_pkg::SUM_W;

  logic signed [SW-1:0] err;
  logic signed [UW:0]   sum_wide;
  logic signed [UW:0]   lim_pos;
  logic signed [UW:0]   lim_neg;
  logic signed [UW:0]   sum_clamped;

  always_comb begin
    unique case (mode)
      pds_pkg::MODE_RIGHT: err = deviation;
      pds_pkg::MODE_LEFT: begin
        // negating the most negative value saturates
        if (deviation == {1'b1, {(SW-1){1'b0}}}) begin
          err = {1'b0, {(SW-1){1'b1}}};
        end else begin
          err = -deviation;
        end
      end
      default: err = '0;
    endcase
  end

  always_comb begin
    sum_wide = {error_sum[UW-1], error_sum} + {{(UW+1-SW){err[SW-1]}}, err};
    lim_pos  = {{(UW+1-pds_pkg::LIMIT_W){1'b0}}, sum_limit};
    lim_neg  = -lim_pos;
    if (err == '0) begin
      sum_clamped = '0;
    end else if (sum_wide > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum_wide < lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      sum_clamped = sum_wide;
    end
  end

  always_comb begin
    if (mode == pds_pkg::MODE_NO_WALL) begin
      res.search = 1'b1;
      res.err    = '0;
      res.sum    = '0;
      res.deriv  = '0;
    end else begin
      res.search = 1'b0;
      res.err    = err;
      res.sum    = sum_clamped[UW-1:0];
      res.deriv  = {err[SW-1], err} - {last_error[SW-1], last_error};
    end
  end

endmodule

`default_nettype wire

/* src/pid_differential_steering_core.sv */
// wall-following pid steering core: register file, pipeline and handshakes
// depends on pds_pkg, pds_if and pds_error_stage
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake          payload
//  cmd       in   valid/ready        mode, deviation
//  result    out  valid/ready        left_speed, right_speed, drive_term, searching
//  cfg       in   cfg_we, no ready   cfg_index, cfg_data
//
//  one command per cycle sustained while results are accepted; five register
//  stages: input, error and integral, three gain multiplies, drive sum and
//  rounding, wheel speeds. the integral and last error update as a command
//  leaves the input stage, so back to back commands see each other's state.
//  each stage holds while the next is full, so a stalled result does not block
//  earlier stages that have bubbles. synchronous reset clears pipeline valids
//  and controller memory and loads default gains, sum limit and cruise speed.

module pid_differential_steering_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  pds_cmd_if.sink                              cmd,
  pds_result_if.source                         result,
  input  wire logic                            cfg_we,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pds_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SW = pds_pkg::SAMPLE_W;

  // configuration
  logic [pds_pkg::GAIN_W-1:0]  gain_p;
  logic [pds_pkg::GAIN_W-1:0]  gain_i;
  logic [pds_pkg::GAIN_W-1:0]  gain_d;
  logic [pds_pkg::LIMIT_W-1:0] sum_limit;
  logic [pds_pkg::BASE_W-1:0]  cruise_speed;

  // controller memory
  logic signed [pds_pkg::SUM_W-1:0] error_sum;
  logic signed [SW-1:0]             last_error;

  // stage registers
  logic                 v1, v2, v3, v4, out_v;
  logic [1:0]           mode1;
  logic signed [SW-1:0] dev1;
  pds_pkg::err_stage_t  s2;
  pds_pkg::err_stage_t  err_res;
  logic                 search3, search4;
  logic signed [pds_pkg::PROD_P_W-1:0] prod_p;
  logic signed [pds_pkg::PROD_I_W-1:0] prod_i;
  logic signed [pds_pkg::PROD_D_W-1:0] prod_d;
  logic signed [SW-1:0] drive4;
  logic signed [SW-1:0] left_q, right_q, drive_q;
  logic                 search_q;

  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic cmd_xfer, s1_xfer;

  logic signed [pds_pkg::ACC_W-1:0]     acc;
  logic signed [pds_pkg::SHIFTED_W-1:0] shifted;
  logic signed [SW-1:0]                 drive_next;
  logic signed [SW:0]                   base_wide;
  logic signed [SW:0]                   drive_wide;

  assign rdy_o = !out_v || result.ready;
  assign rdy4  = !v4 || rdy_o;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;

  assign cmd.ready = rdy1;
  assign cmd_xfer  = cmd.valid && rdy1;
  assign s1_xfer   = v1 && rdy2;

  assign result.valid       = out_v;
  assign result.left_speed  = left_q;
  assign result.right_speed = right_q;
  assign result.drive_term  = drive_q;
  assign result.searching   = search_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= 16'd2048;
      gain_i       <= 16'd82;
      gain_d       <= 16'd410;
      sum_limit    <= 23'd51200;
      cruise_speed <= 15'd5120;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pds_pkg::REG_GAIN_P:       gain_p       <= cfg_data[pds_pkg::GAIN_W-1:0];
        pds_pkg::REG_GAIN_I:       gain_i       <= cfg_data[pds_pkg::GAIN_W-1:0];
        pds_pkg::REG_GAIN_D:       gain_d       <= cfg_data[pds_pkg::GAIN_W-1:0];
        pds_pkg::REG_SUM_LIMIT:    sum_limit    <= cfg_data[pds_pkg::LIMIT_W-1:0];
        pds_pkg::REG_CRUISE_SPEED: cruise_speed <= cfg_data[pds_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  pds_error_stage u_err (
    .mode       (mode1),
    .deviation  (dev1),
    .error_sum  (error_sum),
    .last_error (last_error),
    .sum_limit  (sum_limit),
    .res        (err_res)
  );

  // drive: exact sum, add half, floor, saturate
  always_comb begin
    acc = {{(pds_pkg::ACC_W-pds_pkg::PROD_P_W){prod_p[pds_pkg::PROD_P_W-1]}}, prod_p}
        + {{(pds_pkg::ACC_W-pds_pkg::PROD_I_W){prod_i[pds_pkg::PROD_I_W-1]}}, prod_i}
        + {{(pds_pkg::ACC_W-pds_pkg::PROD_D_W){prod_d[pds_pkg::PROD_D_W-1]}}, prod_d}
        + {{(pds_pkg::ACC_W-pds_pkg::GAIN_FRAC){1'b0}}, 1'b1, {(pds_pkg::GAIN_FRAC-1){1'b0}}};
    shifted = acc[pds_pkg::ACC_W-1:pds_pkg::GAIN_FRAC];
    if (shifted > $signed({{(pds_pkg::SHIFTED_W-SW+1){1'b0}}, {(SW-1){1'b1}}})) begin
      drive_next = {1'b0, {(SW-1){1'b1}}};
    end else if (shifted < $signed({{(pds_pkg::SHIFTED_W-SW+1){1'b1}}, {(SW-1){1'b0}}})) begin
      drive_next = {1'b1, {(SW-1){1'b0}}};
    end else begin
      drive_next = shifted[SW-1:0];
    end
  end

  assign base_wide  = {{(SW+1-pds_pkg::BASE_W){1'b0}}, cruise_speed};
  assign drive_wide = {drive4[SW-1], drive4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      out_v      <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      if (rdy1) v1 <= cmd.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy_o) out_v <= v4;
      if (s1_xfer) begin
        error_sum  <= err_res.sum;
        last_error <= err_res.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      mode1 <= cmd.mode;
      dev1  <= cmd.deviation;
    end
    if (s1_xfer) begin
      s2 <= err_res;
    end
    if (v2 && rdy3) begin
      search3 <= s2.search;
      prod_p  <= $signed({1'b0, gain_p}) * s2.err;
      prod_i  <= $signed({1'b0, gain_i}) * s2.sum;
      prod_d  <= $signed({1'b0, gain_d}) * s2.deriv;
    end
    if (v3 && rdy4) begin
      search4 <= search3;
      drive4  <= drive_next;
    end
    if (v4 && rdy_o) begin
      search_q <= search4;
      if (search4) begin
        left_q  <= -base_wide[SW-1:0];
        right_q <= base_wide[SW-1:0];
        drive_q <= '0;
      end else begin
        left_q  <= pds_pkg::sat_sample(base_wide + drive_wide);
        right_q <= pds_pkg::sat_sample(base_wide - drive_wide);
        drive_q <= drive4;
      end
    end
  end

  // no-wall command clears controller memory as it leaves the input stage
  a_no_wall_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_xfer && mode1 == pds_pkg::MODE_NO_WALL) |=> (error_sum == '0 && last_error == '0))
    else $error("controller memory not cleared by no-wall command");

  // a transfer always lands in the input stage
  a_cmd_lands: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> v1)
    else $error("accepted command lost");

  // searching result carries zero drive and a right speed equal to the cruise speed
  a_search_out: assert property (@(posedge clk) disable iff (rst)
    (out_v && search_q) |-> (drive_q == '0 && right_q == base_wide[SW-1:0]))
    else $error("search result malformed");

  // a stalled drive stage keeps its item until the output stage takes it
  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !rdy_o) |=> v4)
    else $error("drive stage dropped an item");

endmodule

`default_nettype wire

/* dv/tb_pid_differential_steering_core.sv */
// self-checking testbench for pid_differential_steering_core: directed probes, then
// random wall-following traffic over several register settings, scored by a pid predictor
// depends on pds_pkg, pds_if and the core rtl
`timescale 1ns / 1ps

module tb_pid_differential_steering_core;

  localparam int SAMPLE_W  = pds_pkg::SAMPLE_W;
  localparam int GAIN_W    = pds_pkg::GAIN_W;
  localparam int GAIN_FRAC = pds_pkg::GAIN_FRAC;
  localparam int SUM_W     = pds_pkg::SUM_W;
  localparam int LIMIT_W   = pds_pkg::LIMIT_W;
  localparam int BASE_W    = pds_pkg::BASE_W;
  localparam int CFG_W     = pds_pkg::CFG_W;
  localparam int CFG_IDX_W = pds_pkg::CFG_IDX_W;

  localparam int SETTLE        = 8;
  localparam int PROBE_COUNT   = 20;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 155;
  localparam int MAX_REPORTS   = 40;
  localparam longint SAMPLE_HI = 32767;
  localparam longint SAMPLE_LO = -32768;
  // an index past the register list, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_speed;
    logic signed [SAMPLE_W-1:0] right_speed;
    logic signed [SAMPLE_W-1:0] drive_term;
    logic                       searching;
  } wheel_cmd_t;

  typedef struct packed {
    pds_pkg::mode_t             mode;
    logic signed [SAMPLE_W-1:0] dev;
    logic                       typed;
    wheel_cmd_t                 want;
  } probe_t;

  localparam wheel_cmd_t NO_CHECK      = '0;
  localparam wheel_cmd_t SPIN_AT_RESET = '{-16'sd5120, 16'sd5120, 16'sd0, 1'b1};
  localparam wheel_cmd_t CRUISE_AT_RESET = '{16'sd5120, 16'sd5120, 16'sd0, 1'b0};

  // typed rows hold results that follow directly from reset state and default gains
  probe_t probes [PROBE_COUNT] = '{
    '{pds_pkg::MODE_NO_WALL,  16'sh0000, 1'b1, SPIN_AT_RESET},
    '{pds_pkg::MODE_STRAIGHT, 16'sh0000, 1'b1, CRUISE_AT_RESET},
    '{pds_pkg::MODE_RIGHT,    16'sh0000, 1'b1, CRUISE_AT_RESET},
    '{pds_pkg::MODE_RIGHT,    16'sh0100, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_RIGHT,    16'sh7FFF, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_RIGHT,    16'sh7FFF, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_RIGHT,    16'sh7FFF, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_LEFT,     16'sh8000, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_LEFT,     16'sh7FFF, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_RIGHT,    16'sh8000, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_RIGHT,    16'sh8000, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_STRAIGHT, 16'sh04D2, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_LEFT,     16'sh0000, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_NO_WALL,  16'sh7FFF, 1'b1, SPIN_AT_RESET},
    '{pds_pkg::MODE_RIGHT,    16'sh0001, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_RIGHT,    16'shFFFF, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_LEFT,     16'sh0001, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_NO_WALL,  16'sh8000, 1'b1, SPIN_AT_RESET},
    '{pds_pkg::MODE_RIGHT,    16'sh5555, 1'b0, NO_CHECK},
    '{pds_pkg::MODE_LEFT,     16'shAAAA, 1'b0, NO_CHECK}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic rx_ready = 1'b0;

  pds_cmd_if    cmd_ch ();
  pds_result_if res_ch ();

  assign res_ch.ready = rx_ready;

  pid_differential_steering_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and controller memory
  logic [GAIN_W-1:0]          gain_p_q = 16'd2048;
  logic [GAIN_W-1:0]          gain_i_q = 16'd82;
  logic [GAIN_W-1:0]          gain_d_q = 16'd410;
  logic [LIMIT_W-1:0]         limit_q  = 23'd51200;
  logic [BASE_W-1:0]          base_q   = 15'd5120;
  logic signed [SUM_W-1:0]    error_sum_m = '0;
  logic signed [SAMPLE_W-1:0] last_err_m  = '0;

  wheel_cmd_t pending_wheels [$];

  int  faults       = 0;
  int  cmds_sent    = 0;
  int  results_seen = 0;
  int  spins        = 0;
  int  clamp_hits   = 0;
  int  drive_sats   = 0;
  int  settings     = 1;
  int  burst_left;
  bit  cmd_up       = 1'b0;

  function automatic longint clip_sample(longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI;
    if (v < SAMPLE_LO) return SAMPLE_LO;
    return v;
  endfunction

  function automatic wheel_cmd_t predict_wheels(pds_pkg::mode_t m,
                                                logic signed [SAMPLE_W-1:0] dev);
    wheel_cmd_t r;
    longint base, lim, err, sum, deriv, acc, drive;
    r = '0;
    base = longint'(base_q);
    lim = longint'(limit_q);
    if (m == pds_pkg::MODE_NO_WALL) begin
      error_sum_m = '0;
      last_err_m = '0;
      spins++;
      r.left_speed = SAMPLE_W'(clip_sample(-base));
      r.right_speed = SAMPLE_W'(clip_sample(base));
      r.searching = 1'b1;
      return r;
    end
    case (m)
      pds_pkg::MODE_RIGHT: err = longint'(dev);
      pds_pkg::MODE_LEFT:  err = clip_sample(-longint'(dev));
      default:             err = 0;
    endcase
    sum = longint'(error_sum_m) + err;
    if (sum > lim || sum < -lim) clamp_hits++;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    if (err == 0) sum = 0;
    deriv = err - longint'(last_err_m);
    error_sum_m = sum[SUM_W-1:0];
    last_err_m = err[SAMPLE_W-1:0];
    acc = longint'(gain_p_q) * err + longint'(gain_i_q) * sum + longint'(gain_d_q) * deriv
        + (longint'(1) <<< (GAIN_FRAC - 1));
    // arithmetic shift floors, so add-half then shift rounds half up
    drive = acc >>> GAIN_FRAC;
    if (drive != clip_sample(drive)) drive_sats++;
    drive = clip_sample(drive);
    r.left_speed = SAMPLE_W'(clip_sample(base + drive));
    r.right_speed = SAMPLE_W'(clip_sample(base - drive));
    r.drive_term = SAMPLE_W'(drive);
    return r;
  endfunction

  function automatic int new_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(40, 120);
    return $urandom_range(1, 12);
  endfunction

  task automatic send_cmd(input pds_pkg::mode_t m, input logic signed [SAMPLE_W-1:0] dev,
                          input bit typed, input wheel_cmd_t want);
    wheel_cmd_t predicted;
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.deviation <= dev;
    cmd_up = 1'b1;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    predicted = predict_wheels(m, dev);
    pending_wheels.push_back(typed ? want : predicted);
    cmds_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      cmd_ch.valid <= 1'b0;
      cmd_up = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = new_burst();
    end
  endtask

  task automatic wait_drained();
    if (cmd_up) begin
      cmd_ch.valid <= 1'b0;
      cmd_up = 1'b0;
      @(posedge clk);
    end
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pds_pkg::REG_GAIN_P:       gain_p_q = data[GAIN_W-1:0];
      pds_pkg::REG_GAIN_I:       gain_i_q = data[GAIN_W-1:0];
      pds_pkg::REG_GAIN_D:       gain_d_q = data[GAIN_W-1:0];
      pds_pkg::REG_SUM_LIMIT:    limit_q = data[LIMIT_W-1:0];
      pds_pkg::REG_CRUISE_SPEED: base_q = data[BASE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return GAIN_W'($urandom_range(0, 4096));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic set_phase(input int k);
    logic [GAIN_W-1:0]  gp, gi, gd;
    logic [LIMIT_W-1:0] lim;
    logic [BASE_W-1:0]  bs;
    case (k)
      0: begin
        gp = '1; gi = '1; gd = '1; lim = '1; bs = '1;
      end
      1: begin
        gp = '0; gi = '0; gd = '0; lim = '0; bs = '0;
      end
      2: begin
        gp = 16'd2048; gi = 16'd82; gd = 16'd410; lim = 23'd51200; bs = 15'd5120;
      end
      3: begin
        gp = '1; gi = '1; gd = '1; lim = '0; bs = '0;
      end
      default: begin
        gp = pick_gain();
        gi = pick_gain();
        gd = pick_gain();
        case ($urandom_range(0, 3))
          0:       lim = '0;
          1:       lim = '1;
          2:       lim = LIMIT_W'($urandom_range(0, 65536));
          default: lim = LIMIT_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       bs = '0;
          1:       bs = '1;
          default: bs = BASE_W'($urandom);
        endcase
        write_reg(REG_SPARE, CFG_W'($urandom));
      end
    endcase
    // junk above the gain and cruise speed widths must be dropped by the core
    write_reg(pds_pkg::REG_GAIN_P, CFG_W'({$urandom, gp}));
    write_reg(pds_pkg::REG_GAIN_I, CFG_W'({$urandom, gi}));
    write_reg(pds_pkg::REG_GAIN_D, CFG_W'({$urandom, gd}));
    write_reg(pds_pkg::REG_SUM_LIMIT, lim);
    write_reg(pds_pkg::REG_CRUISE_SPEED, CFG_W'({$urandom, bs}));
    settings++;
  endtask

  task automatic random_cmd(output pds_pkg::mode_t m,
                            output logic signed [SAMPLE_W-1:0] dev);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) m = pds_pkg::MODE_RIGHT;
    else if (pick < 80) m = pds_pkg::MODE_LEFT;
    else if (pick < 90) m = pds_pkg::MODE_STRAIGHT;
    else m = pds_pkg::MODE_NO_WALL;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       dev = 16'sh8000;
          1:       dev = 16'sh7FFF;
          2:       dev = 16'sh0000;
          3:       dev = 16'shFFFF;
          default: dev = 16'sh0001;
        endcase
      end
      1, 2, 3: dev = SAMPLE_W'($urandom);
      // small wander around the wall, as in normal tracking
      default: dev = SAMPLE_W'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endtask

  task automatic flag_field(input string name, input logic signed [SAMPLE_W-1:0] exp_v,
                            input logic signed [SAMPLE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      faults++;
      if (faults <= MAX_REPORTS) $error("%s expected %0d got %0d", name, exp_v, act_v);
    end
  endtask

  task automatic take_result();
    wheel_cmd_t want;
    if (pending_wheels.size() == 0) begin
      faults++;
      if (faults <= MAX_REPORTS) $error("result transfer with no command outstanding");
    end else begin
      want = pending_wheels.pop_front();
      results_seen++;
      flag_field("left_speed", want.left_speed, res_ch.left_speed);
      flag_field("right_speed", want.right_speed, res_ch.right_speed);
      flag_field("drive_term", want.drive_term, res_ch.drive_term);
      flag_field("searching", SAMPLE_W'(want.searching), SAMPLE_W'(res_ch.searching));
    end
  endtask

  // receiver: ready follows a 16-bit pattern, reloaded each time it runs out
  logic [15:0] ready_pat;
  logic [3:0]  pat_pos;

  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
      ready_pat <= 16'hFFFF;
      pat_pos <= '0;
    end else begin
      if (res_ch.valid === 1'b1 && rx_ready) take_result();
      rx_ready <= ready_pat[pat_pos];
      pat_pos <= pat_pos + 4'd1;
      if (pat_pos == 4'd15) begin
        case ($urandom_range(0, 3))
          0:       ready_pat <= 16'hFFFF;
          1:       ready_pat <= 16'($urandom | $urandom);
          2:       ready_pat <= 16'($urandom);
          default: ready_pat <= 16'($urandom & $urandom);
        endcase
      end
    end
  end

  initial begin
    pds_pkg::mode_t m;
    logic signed [SAMPLE_W-1:0] dev;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= pds_pkg::MODE_RIGHT;
    cmd_ch.deviation <= '0;
    burst_left = new_burst();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) send_cmd(probes[i].mode, probes[i].dev, probes[i].typed, probes[i].want);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      wait_drained();
      set_phase(k);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // hold the sender once until the pipeline is empty
        if (k == 5 && j == PHASE_ITEMS / 2) wait_drained();
        random_cmd(m, dev);
        send_cmd(m, dev, 1'b0, NO_CHECK);
      end
    end
    wait_drained();

    $display("%0d steering commands, %0d results checked, %0d no-wall spins, %0d settings",
             cmds_sent, results_seen, spins, settings);
    $display("%0d integral clamps, %0d saturated drive terms, %0d faults",
             clamp_hits, drive_sats, faults);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $error("timeout with %0d results outstanding", pending_wheels.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
